[hw/rtl/bencode_token_writer_macros.svh]
// Assertion macros used by the bencode token writer checker.
`ifndef BENCODE_TOKEN_WRITER_MACROS_SVH
`define BENCODE_TOKEN_WRITER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BTW_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BTW_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/btw_pkg.sv]
// Shared constants, codes and types of the bencode token writer.
package btw_pkg;

   // Byte position counter width and the width used to compare it with capacity.
   localparam int POS_W = 32;
   localparam int CMP_W = (POS_W > 32) ? POS_W : 32;

   // A 32-bit magnitude has at most ten decimal digits.
   localparam int DIGITS_MAX = 10;
   localparam int CNT_W      = $clog2(DIGITS_MAX + 1);

   // Fixed-point reciprocal of ten: q = (x * RECIP10) >> RECIP_SHIFT for any 32-bit x.
   localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;

   // Request codes.
   localparam logic [2:0] REQ_LIST = 3'd0;
   localparam logic [2:0] REQ_DICT = 3'd1;
   localparam logic [2:0] REQ_END  = 3'd2;
   localparam logic [2:0] REQ_INT  = 3'd3;
   localparam logic [2:0] REQ_HDR  = 3'd4;
   localparam logic [2:0] REQ_BYTE = 3'd5;

   // Register indexes.
   localparam logic CSR_TARGET_MODE = 1'b0;
   localparam logic CSR_CAPACITY    = 1'b1;

   localparam logic [31:0] CAPACITY_RESET = 32'd4096;

   // Literal bytes of the encoding.
   localparam logic [7:0] CH_I     = 8'h69;
   localparam logic [7:0] CH_E     = 8'h65;
   localparam logic [7:0] CH_L     = 8'h6C;
   localparam logic [7:0] CH_D     = 8'h64;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIGN,
      ST_DIGITS,
      ST_TAIL
   } btw_state_type;

   typedef enum logic [1:0] {
      SRC_LIT,
      SRC_DATA,
      SRC_DIGIT
   } btw_src_type;

   typedef struct packed {
      logic        load_int;
      logic        load_len;
      logic        conv_step;
      logic        emit;
      btw_src_type src;
      logic [7:0]  lit;
      logic        last;
   } btw_cmd_type;

   typedef struct packed {
      logic out_free;
      logic full;
      logic neg;
      logic conv_done;
      logic more;
   } btw_stat_type;

endpackage

[hw/rtl/bencode_token_writer.sv]
// Top level of the bencode token writer: sequencer plus datapath.
//
// Channel   Direction  Word contents
// req_      in         tuser: request kind; tdata: integer, string length, payload byte
// rsp_      out        tdata: byte, position; tuser: written flag, full status; tlast
// csr_      in         write enable, register index, write data (no read-back)
//
// List, dictionary, end and payload byte requests each produce a single word, and a
// stream of payload bytes moves one word per cycle while rsp_tready stays high.
// An integer or string header first runs the divide-by-ten loop in the datapath, one
// digit per cycle; while rsp_tready is high, the minus sign of a negative integer, the
// digits and closing byte move one word per cycle through the single output register.
// Reset is synchronous and active high; it clears the byte position and loads the
// register defaults (buffer mode, capacity 4096).
// A stalled rsp_ tready holds the output word and deasserts req_tready.
module bencode_token_writer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata, lowest bit first: int_value[31:0], string_length[62:32],
   // data_byte[70:63], zero pad [71]
   input  logic [71:0] req_tdata,
   // tuser: req_type[2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata, lowest bit first: out_byte[7:0], position[39:8]
   output logic [39:0] rsp_tdata,
   // tuser, lowest bit first: byte_valid[0], status[1]
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_wen,
   input  logic        csr_addr,
   input  logic [31:0] csr_wdata
);
   import btw_pkg::*;

   // Commands flow from the sequencer into the datapath; status flows back.
   btw_cmd_type  cmd;
   btw_stat_type stat;

   // The sequencer decides which byte goes out next and when a request is over. It
   // accepts a new word only in its idle state and only when the output register can
   // take a word in the same cycle.
   btw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   // The datapath holds the configuration registers, the byte position counter, the
   // digit stack fed by the divide-by-ten step, and the output register. In buffer mode it
   // checks each byte against the capacity at the moment the byte is written, so a refused
   // write turns into an error word with the position left unchanged.
   btw_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[hw/rtl/btw_ctrl.sv]
// Request sequencer of the bencode token writer.
module btw_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [2:0]            req_kind,
   input  btw_pkg::btw_stat_type stat,
   output btw_pkg::btw_cmd_type  cmd
);
   import btw_pkg::*;

   btw_state_type state_ff, state_in;
   logic          is_int_ff, is_int_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         is_int_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         is_int_ff <= is_int_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      is_int_in  = is_int_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.src    = SRC_LIT;
      case (state_ff)
         ST_IDLE: begin
            req_tready = stat.out_free;
            if (req_tvalid && stat.out_free) begin
               case (req_kind)
                  REQ_LIST: begin
                     cmd.emit = 1'b1;
                     cmd.lit  = CH_L;
                     cmd.last = 1'b1;
                  end
                  REQ_DICT: begin
                     cmd.emit = 1'b1;
                     cmd.lit  = CH_D;
                     cmd.last = 1'b1;
                  end
                  REQ_END: begin
                     cmd.emit = 1'b1;
                     cmd.lit  = CH_E;
                     cmd.last = 1'b1;
                  end
                  REQ_BYTE: begin
                     cmd.emit = 1'b1;
                     cmd.src  = SRC_DATA;
                     cmd.last = 1'b1;
                  end
                  REQ_INT: begin
                     cmd.emit     = 1'b1;
                     cmd.lit      = CH_I;
                     cmd.load_int = 1'b1;
                     is_int_in    = 1'b1;
                     if (!stat.full) begin
                        state_in = ST_CONV;
                     end
                  end
                  REQ_HDR: begin
                     cmd.load_len = 1'b1;
                     is_int_in    = 1'b0;
                     state_in     = ST_CONV;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CONV: begin
            cmd.conv_step = 1'b1;
            if (stat.conv_done) begin
               state_in = (is_int_ff && stat.neg) ? ST_SIGN : ST_DIGITS;
            end
         end
         ST_SIGN: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.lit  = CH_MINUS;
               state_in = stat.full ? ST_IDLE : ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.src  = SRC_DIGIT;
               if (stat.full) begin
                  state_in = ST_IDLE;
               end else if (!stat.more) begin
                  state_in = ST_TAIL;
               end
            end
         end
         ST_TAIL: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.lit  = is_int_ff ? CH_E : CH_COLON;
               cmd.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[hw/rtl/btw_datapath.sv]
// Digit conversion, byte position, configuration and output register.
module btw_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [71:0]           req_tdata,
   input  logic                  csr_wen,
   input  logic                  csr_addr,
   input  logic [31:0]           csr_wdata,
   input  btw_pkg::btw_cmd_type  cmd,
   output btw_pkg::btw_stat_type stat,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [39:0]           rsp_tdata,
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast
);
   import btw_pkg::*;

   logic [31:0] int_value;
   logic [30:0] string_length;
   logic [7:0]  data_byte;

   logic             mode_ff, mode_in;
   logic [31:0]      cap_ff, cap_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [31:0]      mag_ff, mag_in;
   logic             neg_ff, neg_in;
   logic [3:0]       digit_ff [DIGITS_MAX];
   logic [3:0]       digit_in [DIGITS_MAX];
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_ok_ff, rsp_ok_in;
   logic        rsp_err_ff, rsp_err_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [31:0] rsp_pos_ff, rsp_pos_in;

   logic [63:0]      prod;
   logic [31:0]      quot;
   logic [31:0]      rem_full;
   logic [3:0]       rem;
   logic             full;
   logic             out_free;
   logic [POS_W-1:0] pos_next;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] pos_next_ext;
   logic [7:0]       emit_byte;

   assign int_value     = req_tdata[31:0];
   assign string_length = req_tdata[62:32];
   assign data_byte     = req_tdata[70:63];

   // One decimal digit per step: quotient by reciprocal multiply, remainder by shift-add.
   assign prod     = 64'(mag_ff) * 64'(RECIP10);
   assign quot     = {3'b000, prod[63:RECIP_SHIFT]};
   assign rem_full = mag_ff - ((quot << 3) + (quot << 1));
   assign rem      = rem_full[3:0];

   assign pos_next     = pos_ff + 1'b1;
   assign pos_ext      = CMP_W'(pos_ff);
   assign pos_next_ext = CMP_W'(pos_next);
   assign full         = !mode_ff && (pos_ext >= CMP_W'(cap_ff));
   assign out_free     = !rsp_valid_ff || rsp_tready;

   assign stat.out_free  = out_free;
   assign stat.full      = full;
   assign stat.neg       = neg_ff;
   assign stat.conv_done = (quot == 32'd0);
   assign stat.more      = (cnt_ff > CNT_W'(1));

   always_comb begin
      case (cmd.src)
         SRC_LIT:   emit_byte = cmd.lit;
         SRC_DATA:  emit_byte = data_byte;
         SRC_DIGIT: emit_byte = CH_ZERO | {4'b0000, digit_ff[0]};
         default:   emit_byte = cmd.lit;
      endcase
   end

   always_comb begin
      mode_in      = mode_ff;
      cap_in       = cap_ff;
      pos_in       = pos_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      digit_in     = digit_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_pos_in   = rsp_pos_ff;

      if (csr_wen) begin
         case (csr_addr)
            CSR_TARGET_MODE: mode_in = csr_wdata[0];
            CSR_CAPACITY:    cap_in  = csr_wdata;
            default: begin
            end
         endcase
      end

      if (cmd.load_int) begin
         neg_in = int_value[31];
         mag_in = int_value[31] ? (~int_value) + 32'd1 : int_value;
         cnt_in = '0;
      end
      if (cmd.load_len) begin
         neg_in = 1'b0;
         mag_in = {1'b0, string_length};
         cnt_in = '0;
      end
      if (cmd.conv_step) begin
         // Push: digits come out least significant first, so the newest sits on top.
         for (int i = DIGITS_MAX - 1; i > 0; i--) begin
            digit_in[i] = digit_ff[i - 1];
         end
         digit_in[0] = rem;
         mag_in      = quot;
         cnt_in      = cnt_ff + 1'b1;
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         if (full) begin
            rsp_byte_in = 8'h00;
            rsp_ok_in   = 1'b0;
            rsp_err_in  = 1'b1;
            rsp_last_in = 1'b1;
            rsp_pos_in  = pos_ext[31:0];
         end else begin
            rsp_byte_in = emit_byte;
            rsp_ok_in   = 1'b1;
            rsp_err_in  = 1'b0;
            rsp_last_in = cmd.last;
            rsp_pos_in  = pos_next_ext[31:0];
            pos_in      = pos_next;
            if (cmd.src == SRC_DIGIT) begin
               for (int i = 0; i < DIGITS_MAX - 1; i++) begin
                  digit_in[i] = digit_ff[i + 1];
               end
               digit_in[DIGITS_MAX - 1] = 4'd0;
               cnt_in = cnt_ff - 1'b1;
            end
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         cap_ff       <= CAPACITY_RESET;
         pos_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         cap_ff       <= cap_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      digit_ff    <= digit_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_err_ff  <= rsp_err_in;
      rsp_last_ff <= rsp_last_in;
      rsp_pos_ff  <= rsp_pos_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_pos_ff, rsp_byte_ff};
   assign rsp_tuser  = {rsp_err_ff, rsp_ok_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

[hw/rtl/btw_chk.sv]
// Port-level checker of the bencode token writer and its bind.
`include "bencode_token_writer_macros.svh"

module btw_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);
   logic [31:0] last_pos_ff;
   logic [31:0] next_pos;
   logic        rsp_take;
   logic        rsp_stall;
   logic        rsp_wr;
   logic        rsp_err;
   logic [31:0] rsp_pos;
   logic [42:0] rsp_word;
   logic        err_shape;

   assign rsp_take  = rsp_tvalid && rsp_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_wr    = rsp_tuser[0];
   assign rsp_err   = rsp_tuser[1];
   assign rsp_pos   = rsp_tdata[39:8];
   assign rsp_word  = {rsp_tlast, rsp_tuser, rsp_tdata};
   assign next_pos  = last_pos_ff + 32'd1;

   // An error word ends its request, carries no byte and is not marked written.
   assign err_shape = rsp_tlast && !rsp_wr && (rsp_tdata[7:0] == 8'h00);

   // Position of the most recent word that carried a written byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_pos_ff <= 32'd0;
      end else if (rsp_take && rsp_wr) begin
         last_pos_ff <= rsp_pos;
      end
   end

   `BTW_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_word), "held word changed")
   `BTW_ASSERT_NOW(a_err_form, rsp_tvalid && rsp_err, err_shape, "error word is malformed")
   `BTW_ASSERT_NOW(a_pos_step, rsp_take && rsp_wr, rsp_pos == next_pos, "bad position step")
   `BTW_ASSERT_NOW(a_pos_err, rsp_take && rsp_err, rsp_pos == last_pos_ff, "error moved position")
   `BTW_ASSERT_NOW(a_no_take_stall, rsp_stall, !req_tready, "request taken while stalled")

endmodule

bind bencode_token_writer btw_chk u_btw_chk (.*);

[tb/tb_top.sv]
// Self-checking testbench for the bencode token writer: stimulus, prediction and checking.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import btw_pkg::*;

   // The two request codes the block ignores have no name in the package.
   localparam logic [2:0] REQ_SPARE_A = 3'd6;
   localparam logic [2:0] REQ_SPARE_B = 3'd7;

   // SETTLE_CYCLES gives the block time to finish any request that produces no word.
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 150;
   localparam int CYCLE_LIMIT   = 300000;

   // One request as the testbench sees it, before packing onto req_tdata and req_tuser.
   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] ival;
      logic [30:0] slen;
      logic [7:0]  dbyte;
   } enc_req_type;

   // One output word with its fields unpacked.
   typedef struct packed {
      logic [7:0]  data;
      logic        written;
      logic        last;
      logic        full;
      logic [31:0] pos;
   } byte_word_type;

   typedef logic [7:0] text_q_type[$];

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata  = '0;
   logic [2:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_wen    = 1'b0;
   logic        csr_addr   = 1'b0;
   logic [31:0] csr_wdata  = '0;

   bencode_token_writer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Requests waiting for the driver, and the words the encoder model says must come out.
   enc_req_type   pending_q[$];
   byte_word_type expected_bytes[$];
   enc_req_type   cur_req;

   // The encoder model's own copy of the position counter and the two registers.
   logic [POS_W-1:0] enc_pos      = '0;
   logic             cfg_stream   = 1'b0;
   logic [31:0]      cfg_capacity = CAPACITY_RESET;

   // Idle control. The stimulus process flips these on the falling edge only.
   bit drv_idle_en = 1'b1;
   bit mon_idle_en = 1'b1;
   int drv_gap     = 0;
   int mon_gap     = 0;
   int hold_asked  = 0;
   int hold_served = 0;
   int hold_left   = 0;

   int unsigned cycle_cnt     = 0;
   int          mismatch_cnt  = 0;
   int          accepted_cnt  = 0;
   int          ignored_cnt   = 0;
   int          words_checked = 0;
   int          refused_cnt   = 0;

   // Decimal digits of an unsigned magnitude, most significant first, "0" for zero.
   function automatic text_q_type decimal_text(input logic [31:0] mag);
      text_q_type digits;
      do begin
         digits.push_front(8'(CH_ZERO + mag % 10));
         mag = mag / 10;
      end while (mag != 0);
      return digits;
   endfunction

   // Works out the words one accepted request produces and queues them. A write is
   // refused in buffer mode once the position has reached the capacity; the refusal
   // is a single error word that ends the request.
   task automatic encode_request(input enc_req_type rq);
      text_q_type    text;
      text_q_type    digits;
      logic [31:0]   mag;
      byte_word_type w;
      bit            refused;
      int            i;
      case (rq.kind)
         REQ_LIST: text.push_back(CH_L);
         REQ_DICT: text.push_back(CH_D);
         REQ_END:  text.push_back(CH_E);
         REQ_INT: begin
            text.push_back(CH_I);
            mag = rq.ival;
            if (rq.ival[31]) begin
               // Two's complement negation also gives the right magnitude for the
               // most negative value when read as unsigned.
               text.push_back(CH_MINUS);
               mag = ~rq.ival + 32'd1;
            end
            digits = decimal_text(mag);
            foreach (digits[j]) text.push_back(digits[j]);
            text.push_back(CH_E);
         end
         REQ_HDR: begin
            digits = decimal_text({1'b0, rq.slen});
            foreach (digits[j]) text.push_back(digits[j]);
            text.push_back(CH_COLON);
         end
         REQ_BYTE: text.push_back(rq.dbyte);
         default:  ignored_cnt++;
      endcase
      refused = 1'b0;
      for (i = 0; i < text.size() && !refused; i++) begin
         if (!cfg_stream && CMP_W'(enc_pos) >= CMP_W'(cfg_capacity)) begin
            refused = 1'b1;
            w = '{data: 8'd0, written: 1'b0, last: 1'b1, full: 1'b1, pos: 32'(enc_pos)};
         end else begin
            enc_pos = enc_pos + 1'b1;
            w = '{data: text[i], written: 1'b1, last: (i == text.size() - 1),
                  full: 1'b0, pos: 32'(enc_pos)};
         end
         expected_bytes.push_back(w);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH at word %0d, %s: got 0x%0h, expected 0x%0h",
               words_checked, what, got, want);
      mismatch_cnt++;
   endtask

   // All fields random, so that the fields a request does not use still toggle.
   function automatic enc_req_type random_fields();
      enc_req_type rq;
      rq.kind  = 3'($urandom);
      rq.ival  = $urandom;
      rq.slen  = 31'($urandom);
      rq.dbyte = 8'($urandom);
      return rq;
   endfunction

   // Queues one request of a given kind; value goes to the field that kind uses.
   task automatic push_directed(input logic [2:0] kind, input logic [31:0] value);
      enc_req_type rq;
      rq      = random_fields();
      rq.kind = kind;
      case (kind)
         REQ_INT:  rq.ival  = value;
         REQ_HDR:  rq.slen  = value[30:0];
         REQ_BYTE: rq.dbyte = value[7:0];
         default:  ;
      endcase
      pending_q.push_back(rq);
   endtask

   // Random traffic shaped like real bencode: payload bytes dominate, and a short
   // string header is mostly followed by exactly that many payload bytes.
   task automatic push_random_items(input int count);
      enc_req_type rq;
      int          pushed;
      int          pick;
      int          k;
      pushed = 0;
      while (pushed < count) begin
         rq   = random_fields();
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            rq.kind = REQ_BYTE;
         end else if (pick < 52) begin
            rq.kind = REQ_INT;
            if ($urandom_range(0, 1) == 0) rq.ival = $urandom_range(0, 2000) - 1000;
         end else if (pick < 68) begin
            rq.kind = REQ_HDR;
            case ($urandom_range(0, 3))
               0: rq.slen = 31'($urandom_range(0, 99999));
               1: ;
               default: rq.slen = 31'($urandom_range(0, 8));
            endcase
         end else if (pick < 97) begin
            case ($urandom_range(0, 2))
               0: rq.kind = REQ_LIST;
               1: rq.kind = REQ_DICT;
               default: rq.kind = REQ_END;
            endcase
         end else begin
            rq.kind = ($urandom_range(0, 1) == 0) ? REQ_SPARE_A : REQ_SPARE_B;
         end
         pending_q.push_back(rq);
         pushed++;
         if (rq.kind == REQ_HDR && rq.slen <= 8 && $urandom_range(0, 4) != 0) begin
            for (k = 0; k < rq.slen; k++) begin
               push_directed(REQ_BYTE, $urandom);
               pushed++;
            end
         end
      end
   endtask

   // Waits until every queued request is taken and every expected word has come,
   // then lets the block settle in case the last request produced no word.
   task automatic wait_for_drain();
      while (pending_q.size() != 0 || req_tvalid || expected_bytes.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Register write, only ever issued while the block is idle. The model's copy
   // follows the register's own masking: the mode keeps bit 0 only.
   task automatic write_csr(input logic idx, input logic [31:0] value);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      if (idx == CSR_TARGET_MODE) cfg_stream = value[0];
      else cfg_capacity = value;
      @(negedge clock);
   endtask

   // Request driver. A word on offer stays put until it is taken; between words it
   // may insert a random idle burst.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         drv_gap    <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            encode_request(cur_req);
            accepted_cnt++;
         end
         if (req_tvalid && !req_tready) begin
            // Holding the current word until the block takes it.
         end else if (drv_gap != 0) begin
            drv_gap    <= drv_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_q.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (drv_idle_en && $urandom_range(0, 3) == 0) begin
            drv_gap    <= $urandom_range(0, 4);
            req_tvalid <= 1'b0;
         end else begin
            cur_req = pending_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {1'b0, cur_req.dbyte, cur_req.slen, cur_req.ival};
            req_tuser  <= cur_req.kind;
         end
      end
   end

   // Long output hold-off. Each request from the stimulus process starts one stretch
   // with rsp_tready low.
   always @(posedge clock) begin
      if (reset) begin
         hold_left   <= 0;
         hold_served <= 0;
      end else if (hold_served != hold_asked) begin
         hold_left   <= HOLD_CYCLES;
         hold_served <= hold_asked;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Output monitor. Every word taken is compared field by field with the oldest
   // expectation; the ready side stalls in random bursts and during the hold-off.
   always @(posedge clock) begin
      byte_word_type got;
      byte_word_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         mon_gap    <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{data: rsp_tdata[7:0], written: rsp_tuser[0], last: rsp_tlast,
                    full: rsp_tuser[1], pos: rsp_tdata[39:8]};
            if (got.full === 1'b1) refused_cnt++;
            if (expected_bytes.size() == 0) begin
               report_mismatch("word with nothing expected", 32'(got.data), 32'd0);
            end else begin
               want = expected_bytes.pop_front();
               if (got.data !== want.data)
                  report_mismatch("out_byte", 32'(got.data), 32'(want.data));
               if (got.written !== want.written)
                  report_mismatch("byte_valid", 32'(got.written), 32'(want.written));
               if (got.last !== want.last)
                  report_mismatch("last", 32'(got.last), 32'(want.last));
               if (got.full !== want.full)
                  report_mismatch("status", 32'(got.full), 32'(want.full));
               if (got.pos !== want.pos) report_mismatch("position", got.pos, want.pos);
            end
            words_checked++;
         end
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
         end else if (mon_gap != 0) begin
            mon_gap    <= mon_gap - 1;
            rsp_tready <= 1'b0;
         end else if (mon_idle_en && $urandom_range(0, 3) == 0) begin
            mon_gap    <= $urandom_range(0, 4);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d words still expected",
                  cycle_cnt, expected_bytes.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // Stimulus sequence, synchronized to the falling edge so that it never races the
   // driver or the monitor on the queues.
   initial begin
      int round;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part with the reset settings: every request kind, the extremes of
      // each field, zero, the most negative integer, and the two ignored selectors.
      push_directed(REQ_LIST, 0);
      push_directed(REQ_DICT, 0);
      push_directed(REQ_END, 0);
      push_directed(REQ_INT, 32'd0);
      push_directed(REQ_INT, 32'hFFFF_FFFF);
      push_directed(REQ_INT, 32'h7FFF_FFFF);
      push_directed(REQ_INT, 32'h8000_0000);
      push_directed(REQ_INT, 32'd1000000000);
      push_directed(REQ_INT, -32'sd9);
      push_directed(REQ_HDR, 32'd0);
      push_directed(REQ_HDR, 32'h7FFF_FFFF);
      push_directed(REQ_HDR, 32'd10);
      push_directed(REQ_BYTE, 32'h00);
      push_directed(REQ_BYTE, 32'hFF);
      push_directed(REQ_BYTE, 32'(CH_E));
      push_directed(REQ_SPARE_A, 0);
      push_directed(REQ_SPARE_B, 0);
      push_directed(REQ_END, 0);
      wait_for_drain();

      // Buffer mode with a capacity just a few bytes ahead of the position, so that
      // refusals land at the start, in the middle and at the end of requests. The
      // first round uses capacity zero, where every write is refused.
      write_csr(CSR_TARGET_MODE, 32'd0);
      for (round = 0; round < 5; round++) begin
         write_csr(CSR_CAPACITY, (round == 0) ? 32'd0 : 32'(enc_pos) + $urandom_range(0, 12));
         push_random_items(12);
         wait_for_drain();
      end

      // Stream mode, capacity from the last buffer round: nothing may be refused. The output
      // side is held off for a long stretch while requests keep coming, so the block backs up
      // and must stall its input. Halfway through, the sender waits for a full drain.
      write_csr(CSR_TARGET_MODE, {31'($urandom_range(0, 32'h7FFF_FFFF)), 1'b1});
      push_random_items(50);
      hold_asked++;
      wait_for_drain();
      push_random_items(50);
      wait_for_drain();

      // Last part: buffer mode with the largest capacity and no idling on either side,
      // so payload bytes have to move at one word per cycle.
      write_csr(CSR_TARGET_MODE, 32'd0);
      write_csr(CSR_CAPACITY, 32'hFFFF_FFFF);
      drv_idle_en = 1'b0;
      mon_idle_en = 1'b0;
      push_random_items(100);
      wait_for_drain();

      $display("Run covered %0d requests (%0d with an unused selector), %0d output words",
               accepted_cnt, ignored_cnt, words_checked);
      $display("Buffer mode at zero, tight and full capacity gave %0d refused writes; %s",
               refused_cnt, "stream mode and a long output stall were also exercised");
      if (mismatch_cnt == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
